// ----- rtl/cavg_pkg.sv -----
// shared widths, control struct and state codes for the cumulative average block
package cavg_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int COUNT_WIDTH  = 16;
    localparam int NUM_WIDTH    = SAMPLE_WIDTH + COUNT_WIDTH + 1;
    localparam int DEN_WIDTH    = COUNT_WIDTH + 1;
    localparam int STEP_WIDTH   = $clog2(NUM_WIDTH);
    localparam int TDATA_IN_WIDTH  = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int TDATA_OUT_WIDTH = ((2 * SAMPLE_WIDTH + COUNT_WIDTH + 7) / 8) * 8;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [STEP_WIDTH-1:0]  MUL_LAST  = STEP_WIDTH'(COUNT_WIDTH - 1);
    localparam logic [STEP_WIDTH-1:0]  DIV_LAST  = STEP_WIDTH'(NUM_WIDTH - 1);

    typedef struct packed {
        logic mul_load;
        logic mul_step;
        logic div_load;
        logic div_step;
    } cavg_ctl_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_PREP = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_FIN  = 5'b10000
    } cavg_state_t;

endpackage

// ----- rtl/cavg_mul.sv -----
// bit-serial shift-add multiplier: numerator = sample + count * mean
module cavg_mul
    import cavg_pkg::*;
(
    input  logic                           aclk,
    input  cavg_ctl_t                      ctl,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic signed [SAMPLE_WIDTH-1:0] mean,
    input  logic        [COUNT_WIDTH-1:0]  count,
    output logic signed [NUM_WIDTH-1:0]    num
);

    logic signed [NUM_WIDTH-1:0]   acc_reg;
    logic signed [NUM_WIDTH-1:0]   mcand_reg;
    logic        [COUNT_WIDTH-1:0] mplier_reg;

    always_ff @(posedge aclk) begin
        if (ctl.mul_load) begin
            acc_reg    <= NUM_WIDTH'(sample);
            mcand_reg  <= NUM_WIDTH'(mean);
            mplier_reg <= count;
        end else if (ctl.mul_step) begin
            if (mplier_reg[0]) begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg <<< 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign num = acc_reg;

endmodule

// ----- rtl/cavg_div.sv -----
// restoring divider, one quotient bit per cycle, truncates toward zero
module cavg_div
    import cavg_pkg::*;
(
    input  logic                           aclk,
    input  cavg_ctl_t                      ctl,
    input  logic signed [NUM_WIDTH-1:0]    num,
    input  logic        [DEN_WIDTH-1:0]    den,
    output logic signed [SAMPLE_WIDTH-1:0] quo
);

    logic [NUM_WIDTH-1:0] dvd_reg;
    logic [DEN_WIDTH-1:0] rem_reg;
    logic                 neg_reg;
    logic [NUM_WIDTH-1:0] num_mag;
    logic [DEN_WIDTH:0]   shifted;
    logic [DEN_WIDTH+1:0] diff;
    logic [SAMPLE_WIDTH-1:0] q_low;

    assign num_mag = num[NUM_WIDTH-1] ? (~num + NUM_WIDTH'(1)) : num;
    assign shifted = {rem_reg, dvd_reg[NUM_WIDTH-1]};
    assign diff    = {1'b0, shifted} - {2'b00, den};

    always_ff @(posedge aclk) begin
        if (ctl.div_load) begin
            dvd_reg <= num_mag;
            rem_reg <= '0;
            neg_reg <= num[NUM_WIDTH-1];
        end else if (ctl.div_step) begin
            if (!diff[DEN_WIDTH+1]) begin
                rem_reg <= diff[DEN_WIDTH-1:0];
                dvd_reg <= {dvd_reg[NUM_WIDTH-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[DEN_WIDTH-1:0];
                dvd_reg <= {dvd_reg[NUM_WIDTH-2:0], 1'b0};
            end
        end
    end

    assign q_low = dvd_reg[SAMPLE_WIDTH-1:0];
    assign quo   = neg_reg ? signed'(~q_low + SAMPLE_WIDTH'(1)) : signed'(q_low);

endmodule

// ----- rtl/cumulative_average_2d.sv -----
// top level: cumulative average of 2-d samples with serial multiply and divide
// flow: a first sample or a restart goes from accept straight to the update;
//   otherwise accept, multiply, divider load, divide, then update
// one item at a time: no new sample is accepted until the update of the last,
//   which waits on the shift-add multiplier, the restoring divider and m_tready
// reset: synchronous active-low aresetn clears means, count and handshake state
module cumulative_average_2d
    import cavg_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [TDATA_IN_WIDTH-1:0]  s_tdata,   // sample_x, sample_y
    input  logic                       s_tuser,   // restart
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [TDATA_OUT_WIDTH-1:0] m_tdata    // mean_x, mean_y, samples_seen
);

    cavg_state_t state_reg, state_next;
    logic [STEP_WIDTH-1:0]  step_reg, step_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic                   direct_reg, direct_next;
    logic signed [SAMPLE_WIDTH-1:0] mean_x_reg, mean_x_next;
    logic signed [SAMPLE_WIDTH-1:0] mean_y_reg, mean_y_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic signed [SAMPLE_WIDTH-1:0] smp_x_reg, smp_y_reg;

    logic signed [SAMPLE_WIDTH-1:0] in_x, in_y;
    logic signed [NUM_WIDTH-1:0]    num_x, num_y;
    logic signed [SAMPLE_WIDTH-1:0] quo_x, quo_y;
    logic [DEN_WIDTH-1:0]           den;
    logic                           accept;
    cavg_ctl_t                      ctl;

    assign in_x   = signed'(s_tdata[SAMPLE_WIDTH-1:0]);
    assign in_y   = signed'(s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]);
    assign den    = DEN_WIDTH'(count_reg) + DEN_WIDTH'(1);
    assign accept = s_tvalid && s_tready;

    cavg_mul u_mul_x (
        .aclk   (aclk),
        .ctl    (ctl),
        .sample (in_x),
        .mean   (mean_x_reg),
        .count  (count_reg),
        .num    (num_x)
    );

    cavg_mul u_mul_y (
        .aclk   (aclk),
        .ctl    (ctl),
        .sample (in_y),
        .mean   (mean_y_reg),
        .count  (count_reg),
        .num    (num_y)
    );

    cavg_div u_div_x (
        .aclk (aclk),
        .ctl  (ctl),
        .num  (num_x),
        .den  (den),
        .quo  (quo_x)
    );

    cavg_div u_div_y (
        .aclk (aclk),
        .ctl  (ctl),
        .num  (num_y),
        .den  (den),
        .quo  (quo_y)
    );

    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        direct_next   = direct_reg;
        mean_x_next   = mean_x_reg;
        mean_y_next   = mean_y_reg;
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        ctl           = '0;
        s_tready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser || count_reg == '0) begin
                        direct_next = 1'b1;
                        state_next  = ST_FIN;
                    end else begin
                        direct_next  = 1'b0;
                        ctl.mul_load = 1'b1;
                        step_next    = MUL_LAST;
                        state_next   = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                ctl.mul_step = 1'b1;
                step_next    = step_reg - STEP_WIDTH'(1);
                if (step_reg == '0) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                ctl.div_load = 1'b1;
                step_next    = DIV_LAST;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                ctl.div_step = 1'b1;
                step_next    = step_reg - STEP_WIDTH'(1);
                if (step_reg == '0) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    if (direct_reg) begin
                        mean_x_next = smp_x_reg;
                        mean_y_next = smp_y_reg;
                        count_next  = COUNT_WIDTH'(1);
                    end else begin
                        mean_x_next = quo_x;
                        mean_y_next = quo_y;
                        if (count_reg != COUNT_MAX) begin
                            count_next = count_reg + COUNT_WIDTH'(1);
                        end
                    end
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            direct_reg   <= 1'b0;
            mean_x_reg   <= '0;
            mean_y_reg   <= '0;
            count_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
            direct_reg   <= direct_next;
            mean_x_reg   <= mean_x_next;
            mean_y_reg   <= mean_y_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            smp_x_reg <= in_x;
            smp_y_reg <= in_y;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_OUT_WIDTH'({count_reg, mean_y_reg, mean_x_reg});

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> count_reg != '0)
        else $error("result shown with zero count");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("input ready right after accept");

    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result raised outside final state");

    a_state_held_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL || state_reg == ST_DIV || state_reg == ST_PREP)
        |=> $stable(count_reg) && $stable(mean_x_reg))
        else $error("running state changed mid-item");

endmodule

// ----- verif/cumulative_average_2d_tb.sv -----
// self-checking testbench for cumulative_average_2d: directed, long-run and random runs
module cumulative_average_2d_tb
    import cavg_pkg::*;
();

    localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_M1  = {SAMPLE_WIDTH{1'b1}};
    localparam int RANDOM_ITEMS = 1100;
    localparam int LONG_RUN_ITEMS = 30;
    localparam int TAIL_CYCLES = 80;

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] mx;
        logic [SAMPLE_WIDTH-1:0] my;
        logic [COUNT_WIDTH-1:0]  cnt;
    } mean_item_t;

    class cavg_scoreboard;
        logic signed [SAMPLE_WIDTH-1:0] avg_x;
        logic signed [SAMPLE_WIDTH-1:0] avg_y;
        logic [COUNT_WIDTH-1:0]         count;
        mean_item_t                     expected_means[$];
        int                             mismatches;

        function new();
            avg_x = '0;
            avg_y = '0;
            count = '0;
            mismatches = 0;
        endfunction

        function logic signed [SAMPLE_WIDTH-1:0] blend_mean(
            logic signed [SAMPLE_WIDTH-1:0] mean, logic signed [SAMPLE_WIDTH-1:0] smp);
            longint num;
            longint den;
            num = longint'(smp) + longint'(count) * longint'(mean);
            den = longint'(count) + 1;
            return SAMPLE_WIDTH'(num / den);
        endfunction

        function void note_sample(logic [SAMPLE_WIDTH-1:0] x, logic [SAMPLE_WIDTH-1:0] y,
                                  logic restart);
            mean_item_t e;
            if (restart || count == '0) begin
                avg_x = x;
                avg_y = y;
                count = COUNT_WIDTH'(1);
            end else begin
                avg_x = blend_mean(avg_x, x);
                avg_y = blend_mean(avg_y, y);
                if (count != COUNT_MAX)
                    count = count + 1'b1;
            end
            e.mx = avg_x;
            e.my = avg_y;
            e.cnt = count;
            expected_means.push_back(e);
        endfunction

        function void check_result(logic [SAMPLE_WIDTH-1:0] mx, logic [SAMPLE_WIDTH-1:0] my,
                                   logic [COUNT_WIDTH-1:0] cnt);
            mean_item_t e;
            if (expected_means.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: x=%0d y=%0d n=%0d",
                             $signed(mx), $signed(my), cnt);
                return;
            end
            e = expected_means.pop_front();
            if (e.mx !== mx || e.my !== my || e.cnt !== cnt) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mean mismatch: expected x=%0d y=%0d n=%0d, got x=%0d y=%0d n=%0d",
                             $signed(e.mx), $signed(e.my), e.cnt,
                             $signed(mx), $signed(my), cnt);
            end
        endfunction

        function int pending();
            return expected_means.size();
        endfunction
    endclass

    logic                       aclk;
    logic                       aresetn;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [TDATA_IN_WIDTH-1:0]  s_tdata;
    logic                       s_tuser;
    logic                       m_tvalid;
    logic                       m_tready;
    logic [TDATA_OUT_WIDTH-1:0] m_tdata;

    cavg_scoreboard sb = new();
    bit             quiet;
    int             hold_len;

    cumulative_average_2d u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata[SAMPLE_WIDTH-1:0],
                            m_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH],
                            m_tdata[2*SAMPLE_WIDTH+COUNT_WIDTH-1:2*SAMPLE_WIDTH]);
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_len > 0) begin
                m_tready <= 1'b0;
                repeat (hold_len) @(posedge aclk);
                hold_len = 0;
            end else if (!quiet && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge aclk);
            end
        end
    end

    function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 4))
                    0: return SAMPLE_MIN;
                    1: return SAMPLE_MAX;
                    2: return '0;
                    3: return SAMPLE_M1;
                    default: return SAMPLE_WIDTH'(1);
                endcase
            end
            1, 2: return SAMPLE_WIDTH'($urandom_range(0, 1024)) - SAMPLE_WIDTH'(512);
            default: return SAMPLE_WIDTH'($urandom());
        endcase
    endfunction

    task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] x,
                               input logic [SAMPLE_WIDTH-1:0] y, input logic restart);
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_IN_WIDTH'({y, x});
        s_tuser  <= restart;
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(x, y, restart);
    endtask

    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    endtask

    task automatic wait_for_means();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    initial begin
        int sent;
        int run_len;
        int k;
        bit fresh;
        logic rst;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        quiet    = 1'b0;
        hold_len = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, restart with history, truncation toward zero
        send_sample(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        send_sample('0, '0, 1'b0);
        send_sample(SAMPLE_M1, SAMPLE_WIDTH'(1), 1'b0);
        send_sample(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_WIDTH'(100), SAMPLE_WIDTH'(-100), 1'b1);
        send_sample(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_M1, SAMPLE_M1, 1'b1);
        send_sample('0, '0, 1'b0);
        send_sample(SAMPLE_WIDTH'(1), SAMPLE_M1, 1'b1);
        send_sample('0, '0, 1'b0);
        send_sample(SAMPLE_WIDTH'('h5555), SAMPLE_WIDTH'('haaaa), 1'b1);
        send_sample(SAMPLE_WIDTH'('haaaa), SAMPLE_WIDTH'('h5555), 1'b0);
        send_sample(SAMPLE_MIN, SAMPLE_MIN, 1'b1);
        send_sample(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
        send_sample(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_WIDTH'(-3), SAMPLE_WIDTH'(3), 1'b0);
        wait_for_means();

        // long run with restarts only at its start and end, no stalls
        quiet = 1'b1;
        send_sample(pick_sample(), pick_sample(), 1'b1);
        for (k = 0; k < LONG_RUN_ITEMS; k++)
            send_sample(pick_sample(), pick_sample(), 1'b0);
        send_sample(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
        wait_for_means();
        quiet = 1'b0;

        // random runs, mostly restart-led sequences
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 40);
            fresh = ($urandom_range(0, 7) != 0);
            for (k = 0; k < run_len && sent < RANDOM_ITEMS; k++) begin
                rst = (k == 0) ? fresh : ($urandom_range(0, 39) == 0);
                if (sent == 300)
                    hold_len = 400;
                if (sent == 600) begin
                    wait_for_means();
                    repeat ($urandom_range(1, 13)) @(posedge aclk);
                end
                if (sent == RANDOM_ITEMS - 150)
                    quiet = 1'b1;
                sender_gap();
                send_sample(pick_sample(), pick_sample(), rst);
                sent++;
            end
        end

        wait_for_means();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/cavg_pkg.sv
rtl/cavg_mul.sv
rtl/cavg_div.sv
rtl/cumulative_average_2d.sv
verif/cumulative_average_2d_tb.sv
